[design/lrupr_pkg.sv]
// Shared constants, outcome and state codes, and controller/datapath
// command and status structs for the LRU page replacement block.
// No dependencies.
package lrupr_pkg;

  localparam int PROCESSES         = 32;
  localparam int PAGES_PER_PROCESS = 32;
  localparam int PAGE_SIZE         = 128;

  localparam int PROC_W   = 5;
  localparam int PC_W     = 12;
  localparam int MASK_W   = 32;
  localparam int TICK_W   = 32;
  localparam int OUT_W    = 3;
  localparam int VICTIM_W = 5;

  typedef enum logic [OUT_W-1:0] {
    OUT_SKIP   = 3'd0,
    OUT_HIT    = 3'd1,
    OUT_PAGEIN = 3'd2,
    OUT_EVICT  = 3'd3,
    OUT_NONE   = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic clr_step;
    logic capture;
    logic stamp;
    logic scan_start;
    logic scan_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_scan;
    logic scan_done;
    logic out_busy;
  } dp_sts_t;

endpackage

[design/lrupr_item_if.sv]
// Input item channel: valid/ready handshake plus one process visit.
// Depends on lrupr_pkg for field widths.
interface lrupr_item_if;
  logic                         valid;
  logic                         ready;
  logic [lrupr_pkg::PROC_W-1:0] process;
  logic                         process_active;
  logic [lrupr_pkg::PC_W-1:0]   program_counter;
  logic [lrupr_pkg::MASK_W-1:0] resident_mask;
  logic                         frame_free;
  logic                         last_in_tick;

  modport source (output valid, process, process_active, program_counter, resident_mask,
                  frame_free, last_in_tick, input ready);
  modport sink (input valid, process, process_active, program_counter, resident_mask,
                frame_free, last_in_tick, output ready);
endinterface

[design/lrupr_result_if.sv]
// Result item channel: valid/ready handshake plus outcome and victim page.
// Depends on lrupr_pkg for field widths.
interface lrupr_result_if;
  logic                           valid;
  logic                           ready;
  logic [lrupr_pkg::OUT_W-1:0]    outcome;
  logic [lrupr_pkg::VICTIM_W-1:0] victim_page;

  modport source (output valid, outcome, victim_page, input ready);
  modport sink (input valid, outcome, victim_page, output ready);
endinterface

[design/lru_page_replacement_top.sv]
// Top level of the per-process LRU page replacement block.
// Depends on lrupr_pkg, lrupr_item_if, lrupr_result_if, lrupr_ctrl, lrupr_dp.
//
//   channel   direction  handshake      payload
//   item_i    in         valid/ready    process, process_active, program_counter,
//                                       resident_mask, frame_free, last_in_tick
//   result_o  out        valid/ready    outcome, victim_page
//
// One item in flight. Skip, hit, page-in and nothing-resident pass from accept
// through DECIDE to FINISH, which loads the result register; an eviction also passes
// through SCAN, a serial read of one page stamp per cycle from the stamp RAM over
// min(PAGES_PER_PROCESS, 32) pages. After reset a clearing pass zeroes all
// PROCESSES * PAGES_PER_PROCESS RAM entries; item_i.ready stays low until it ends.
// A new item is taken while a result waits in the output register; the next
// result holds until that one is taken.
module lru_page_replacement_top #(
  parameter int PROCESSES         = lrupr_pkg::PROCESSES,
  parameter int PAGES_PER_PROCESS = lrupr_pkg::PAGES_PER_PROCESS,
  parameter int PAGE_SIZE         = lrupr_pkg::PAGE_SIZE
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  lrupr_item_if.sink     item_i,
  lrupr_result_if.source result_o
);

  lrupr_pkg::dp_cmd_t cmd;
  lrupr_pkg::dp_sts_t sts;

  lrupr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrupr_dp #(
    .PROCESSES         (PROCESSES),
    .PAGES_PER_PROCESS (PAGES_PER_PROCESS),
    .PAGE_SIZE         (PAGE_SIZE)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .result_o (result_o),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

endmodule

[design/lrupr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrupr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/lrupr_ctrl.sv]
// Controller state machine: clearing pass, accept, decide, victim scan, result.
// Depends on lrupr_pkg (state enum, command and status structs).
module lrupr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lrupr_pkg::dp_sts_t sts_i,
  output lrupr_pkg::dp_cmd_t cmd_o
);

  lrupr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrupr_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lrupr_pkg::ST_CLEAR: begin
        if (sts_i.clr_done) state_d = lrupr_pkg::ST_IDLE;
      end
      lrupr_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = lrupr_pkg::ST_DECIDE;
      end
      lrupr_pkg::ST_DECIDE: begin
        state_d = sts_i.need_scan ? lrupr_pkg::ST_SCAN : lrupr_pkg::ST_FINISH;
      end
      lrupr_pkg::ST_SCAN: begin
        if (sts_i.scan_done) state_d = lrupr_pkg::ST_FINISH;
      end
      lrupr_pkg::ST_FINISH: begin
        if (!sts_i.out_busy) state_d = lrupr_pkg::ST_IDLE;
      end
      default: state_d = lrupr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      lrupr_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
      end
      lrupr_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      lrupr_pkg::ST_DECIDE: begin
        cmd_o.stamp      = 1'b1;
        cmd_o.scan_start = sts_i.need_scan;
      end
      lrupr_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      lrupr_pkg::ST_FINISH: begin
        cmd_o.load_out = !sts_i.out_busy;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

[design/lrupr_dp.sv]
// Datapath: item registers, tick counter, page stamp RAM, serial victim scan
// and result register. Depends on lrupr_pkg, lrupr_ram and the channel interfaces.
module lrupr_dp #(
  parameter int PROCESSES         = lrupr_pkg::PROCESSES,
  parameter int PAGES_PER_PROCESS = lrupr_pkg::PAGES_PER_PROCESS,
  parameter int PAGE_SIZE         = lrupr_pkg::PAGE_SIZE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lrupr_item_if.sink         item_i,
  lrupr_result_if.source     result_o,
  input  lrupr_pkg::dp_cmd_t cmd_i,
  output lrupr_pkg::dp_sts_t sts_o
);

  localparam int MaskPages = (PAGES_PER_PROCESS < 32) ? PAGES_PER_PROCESS : 32;
  localparam int PageW     = (MaskPages > 1) ? $clog2(MaskPages) : 1;
  localparam int CntW      = $clog2(MaskPages + 1);
  localparam int Depth     = PROCESSES * PAGES_PER_PROCESS;
  localparam int AddrW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PcW       = lrupr_pkg::PC_W;
  localparam int TickW     = lrupr_pkg::TICK_W;
  localparam int DivShift  = PcW + $clog2(PAGE_SIZE);
  localparam int MulW      = PcW + 2;
  localparam longint unsigned DivMul =
      ((64'd1 << DivShift) + 64'(PAGE_SIZE) - 64'd1) / 64'(PAGE_SIZE);
  localparam logic [MulW-1:0] DivMulC = MulW'(DivMul);
  localparam logic [32:0] MaskKeepW = (33'd1 << MaskPages) - 33'd1;
  localparam logic [lrupr_pkg::MASK_W-1:0] MaskKeep = MaskKeepW[31:0];

  // item registers
  logic [lrupr_pkg::PROC_W-1:0] proc_q;
  logic                         active_q;
  logic [PcW-1:0]               page_q;
  logic [lrupr_pkg::MASK_W-1:0] mask_q;
  logic                         free_q;
  logic [TickW-1:0]             item_tick_q;
  logic [TickW-1:0]             tick_q;

  // scan state
  logic [AddrW-1:0] clr_cnt_q;
  logic [CntW-1:0]  scan_cnt_q;
  logic             rd_vld_q;
  logic [PageW-1:0] rd_pg_q;
  logic [TickW:0]   best_q;
  logic [PageW-1:0] victim_q;
  logic             found_q;

  // result register
  logic                           out_valid_q;
  lrupr_pkg::outcome_e            outcome_q;
  logic [lrupr_pkg::VICTIM_W-1:0] victim_out_q;

  logic [PcW+MulW-1:0] page_prod;
  logic [PcW-1:0]      page_d;
  logic [AddrW-1:0]    row_base;
  logic                proc_ok;
  logic                page_in_row;
  logic                resident;
  lrupr_pkg::outcome_e outcome_dec;
  logic                scan_issue;
  logic                ram_we;
  logic [AddrW-1:0]    ram_waddr;
  logic [TickW-1:0]    ram_wdata;
  logic [AddrW-1:0]    ram_raddr;
  logic [TickW-1:0]    ram_rdata;

  // page = pc / PAGE_SIZE by exact reciprocal multiply
  assign page_prod = (PcW+MulW)'(item_i.program_counter) * (PcW+MulW)'(DivMulC);
  assign page_d    = PcW'(page_prod >> DivShift);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      proc_q      <= item_i.process;
      active_q    <= item_i.process_active;
      page_q      <= page_d;
      mask_q      <= item_i.resident_mask & MaskKeep;
      free_q      <= item_i.frame_free;
      item_tick_q <= tick_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= TickW'(1);
    end else if (cmd_i.capture && item_i.last_in_tick && (tick_q != '1)) begin
      tick_q <= tick_q + TickW'(1);
    end
  end

  assign row_base    = AddrW'(32'(proc_q) * 32'(PAGES_PER_PROCESS));
  assign proc_ok     = 32'(proc_q) < 32'(PROCESSES);
  assign page_in_row = 32'(page_q) < 32'(PAGES_PER_PROCESS);
  assign resident    = (32'(page_q) < 32'(MaskPages)) && mask_q[page_q[PageW-1:0]];

  always_comb begin
    if (!(active_q && proc_ok)) begin
      outcome_dec = lrupr_pkg::OUT_SKIP;
    end else if (resident) begin
      outcome_dec = lrupr_pkg::OUT_HIT;
    end else if (free_q) begin
      outcome_dec = lrupr_pkg::OUT_PAGEIN;
    end else if (mask_q == '0) begin
      outcome_dec = lrupr_pkg::OUT_NONE;
    end else begin
      outcome_dec = lrupr_pkg::OUT_EVICT;
    end
  end

  // stamp RAM ports
  assign scan_issue = cmd_i.scan_step && (scan_cnt_q != CntW'(MaskPages));
  assign ram_raddr  = row_base + AddrW'(scan_cnt_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata = '0;
    if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.stamp && active_q && proc_ok && page_in_row) begin
      ram_we    = 1'b1;
      ram_waddr = row_base + AddrW'(page_q);
      ram_wdata = item_tick_q;
    end
  end

  lrupr_ram #(
    .WIDTH (TickW),
    .DEPTH (Depth)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + AddrW'(1);
    end
  end

  // serial scan: issue one read per cycle, compare the returning stamp
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd_i.scan_start) begin
      scan_cnt_q <= '0;
      rd_vld_q   <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd_i.scan_step) begin
      rd_vld_q <= scan_issue;
      if (scan_issue) scan_cnt_q <= scan_cnt_q + CntW'(1);
      if (rd_vld_q && mask_q[rd_pg_q] && !found_q && ({1'b0, ram_rdata} < best_q) &&
          (ram_rdata <= TickW'(1))) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      best_q   <= {1'b0, item_tick_q} + (TickW+1)'(1);
      victim_q <= '0;
    end else if (cmd_i.scan_step) begin
      rd_pg_q <= scan_cnt_q[PageW-1:0];
      if (rd_vld_q && mask_q[rd_pg_q] && !found_q && ({1'b0, ram_rdata} < best_q)) begin
        best_q   <= {1'b0, ram_rdata};
        victim_q <= rd_pg_q;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      outcome_q    <= outcome_dec;
      victim_out_q <= (outcome_dec == lrupr_pkg::OUT_EVICT) ?
                      lrupr_pkg::VICTIM_W'(victim_q) : '0;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.outcome     = outcome_q;
  assign result_o.victim_page = victim_out_q;

  assign sts_o.clr_done  = clr_cnt_q == AddrW'(Depth - 1);
  assign sts_o.need_scan = outcome_dec == lrupr_pkg::OUT_EVICT;
  assign sts_o.scan_done = (scan_cnt_q == CntW'(MaskPages)) && !rd_vld_q;
  assign sts_o.out_busy  = out_valid_q && !result_o.ready;

  // tick counter never wraps to zero
  a_tick_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_q != '0)
    else $error("tick counter reached zero");

  // an early stop only happens on a stamp of one or less
  a_found_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (best_q <= (TickW+1)'(1)))
    else $error("scan stopped early without a low stamp");

  // the chosen victim is a resident page
  a_victim_resident: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_out && (outcome_dec == lrupr_pkg::OUT_EVICT)) |-> mask_q[victim_q])
    else $error("victim page is not resident");

  // victim field is zero unless an eviction is reported
  a_victim_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (outcome_q != lrupr_pkg::OUT_EVICT)) |-> (victim_out_q == '0))
    else $error("victim page set without eviction");

endmodule

[tb/lru_page_replacement_top_test.sv]
`timescale 1ns / 100ps
// Testbench for lru_page_replacement_top: directed and random process visits,
// checked against a timestamp LRU predictor. Depends on lrupr_pkg, lrupr_item_if,
// lrupr_result_if and the block's RTL.
module lru_page_replacement_top_test;

  localparam int PROCESSES         = lrupr_pkg::PROCESSES;
  localparam int PAGES_PER_PROCESS = lrupr_pkg::PAGES_PER_PROCESS;
  localparam int PAGE_SIZE         = lrupr_pkg::PAGE_SIZE;
  localparam int PROC_W            = lrupr_pkg::PROC_W;
  localparam int PC_W              = lrupr_pkg::PC_W;
  localparam int MASK_W            = lrupr_pkg::MASK_W;
  localparam int TICK_W            = lrupr_pkg::TICK_W;
  localparam int VICTIM_W          = lrupr_pkg::VICTIM_W;

  localparam int MASK_PAGES   = (PAGES_PER_PROCESS < 32) ? PAGES_PER_PROCESS : 32;
  localparam int LIMIT_CYCLES = 400_000;
  localparam int MAX_IDLE     = 13;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [PROC_W-1:0] process;
    logic              active;
    logic [PC_W-1:0]   pc;
    logic [MASK_W-1:0] mask;
    logic              frame_free;
    logic              last;
  } visit_t;

  typedef struct packed {
    lrupr_pkg::outcome_e   outcome;
    logic [VICTIM_W-1:0]   victim_page;
  } decision_t;

  logic clk_i = 1'b0;
  logic rst_n;

  lrupr_item_if   item_if ();
  lrupr_result_if res_if ();

  lru_page_replacement_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_n),
    .item_i   (item_if),
    .result_o (res_if)
  );

  always #5 clk_i = ~clk_i;

  logic [TICK_W-1:0] tick_now = 1;
  logic [TICK_W-1:0] page_stamp [PROCESSES*PAGES_PER_PROCESS] = '{default: '0};
  decision_t         pending_decisions [$];

  bit src_idle_on   = 1'b1;
  bit snk_idle_on   = 1'b1;
  int stall_request = 0;
  int error_count   = 0;
  int visits_sent   = 0;
  int ticks_closed  = 0;
  int results_taken = 0;
  int outcome_seen [5] = '{default: 0};
  int cycle_count   = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               pending_decisions.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic decision_t predict_decision(input visit_t v);
    decision_t   d;
    int unsigned page;
    logic [31:0] mask;
    logic [32:0] best;
    logic [31:0] st;
    bit          found;
    d.outcome     = lrupr_pkg::OUT_SKIP;
    d.victim_page = '0;
    mask          = v.mask;
    found         = 1'b0;
    if (MASK_PAGES < 32) mask &= (32'h1 << MASK_PAGES) - 32'h1;
    if (v.active && v.process < PROCESSES) begin
      page = v.pc / PAGE_SIZE;
      if (page < PAGES_PER_PROCESS) page_stamp[v.process*PAGES_PER_PROCESS + page] = tick_now;
      if (page < MASK_PAGES && mask[page]) begin
        d.outcome = lrupr_pkg::OUT_HIT;
      end else if (v.frame_free) begin
        d.outcome = lrupr_pkg::OUT_PAGEIN;
      end else if (mask == '0) begin
        d.outcome = lrupr_pkg::OUT_NONE;
      end else begin
        d.outcome = lrupr_pkg::OUT_EVICT;
        best      = {1'b0, tick_now} + 33'd1;
        for (int p = 0; p < MASK_PAGES && !found; p++) begin
          if (mask[p]) begin
            st = page_stamp[v.process*PAGES_PER_PROCESS + p];
            if ({1'b0, st} < best) begin
              best          = {1'b0, st};
              d.victim_page = VICTIM_W'(p);
              if (st <= 32'd1) found = 1'b1;
            end
          end
        end
      end
    end
    if (v.last && tick_now != '1) tick_now++;
    return d;
  endfunction

  function automatic visit_t make_visit(input int proc, input bit active, input int pc,
                                        input logic [31:0] mask, input bit ff, input bit last);
    visit_t v;
    v.process    = PROC_W'(proc);
    v.active     = active;
    v.pc         = PC_W'(pc);
    v.mask       = mask;
    v.frame_free = ff;
    v.last       = last;
    return v;
  endfunction

  task automatic send_visit(input visit_t v);
    int gap;
    gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_if.valid           <= 1'b1;
    item_if.process         <= v.process;
    item_if.process_active  <= v.active;
    item_if.program_counter <= v.pc;
    item_if.resident_mask   <= v.mask;
    item_if.frame_free      <= v.frame_free;
    item_if.last_in_tick    <= v.last;
    do @(posedge clk_i); while (!item_if.ready);
    pending_decisions.push_back(predict_decision(v));
    visits_sent++;
    if (v.last) ticks_closed++;
  endtask

  task automatic test_directed_cases();
    send_visit(make_visit(0, 1'b1, 'h000, 32'h0000_0000, 1'b0, 1'b0));
    send_visit(make_visit(3, 1'b0, 'hFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_visit(make_visit(31, 1'b1, 'hFFF, 32'h8000_0000, 1'b0, 1'b0));
    send_visit(make_visit(31, 1'b1, 'h080, 32'h8000_0000, 1'b1, 1'b0));
    send_visit(make_visit(31, 1'b1, 'h080, 32'h8000_0000, 1'b0, 1'b1));
    send_visit(make_visit(0, 1'b1, 'h0FF, 32'h0000_0003, 1'b0, 1'b0));
    send_visit(make_visit(0, 1'b1, 'h100, 32'h0000_0003, 1'b0, 1'b1));
    send_visit(make_visit(5, 1'b1, 'h100, 32'h0000_0000, 1'b1, 1'b1));
    send_visit(make_visit(5, 1'b1, 'h180, 32'h0000_0000, 1'b1, 1'b1));
    send_visit(make_visit(5, 1'b1, 'h200, 32'h0000_0000, 1'b1, 1'b1));
    send_visit(make_visit(5, 1'b1, 'h500, 32'h0000_001C, 1'b0, 1'b0));
    send_visit(make_visit(5, 1'b1, 'h100, 32'h0000_001C, 1'b1, 1'b1));
    send_visit(make_visit(5, 1'b1, 'h500, 32'h0000_001C, 1'b0, 1'b0));
    send_visit(make_visit(5, 1'b1, 'h300, 32'h0000_0000, 1'b1, 1'b0));
    send_visit(make_visit(5, 1'b1, 'h380, 32'h0000_0000, 1'b1, 1'b1));
    send_visit(make_visit(5, 1'b1, 'h500, 32'h0000_00C0, 1'b0, 1'b0));
    send_visit(make_visit(5, 1'b1, 'h500, 32'h0010_0010, 1'b0, 1'b0));
    send_visit(make_visit(5, 1'b1, 'h500, 32'h0000_1200, 1'b0, 1'b0));
    send_visit(make_visit(6, 1'b0, 'h000, 32'h0000_0000, 1'b0, 1'b0));
    send_visit(make_visit(31, 1'b1, 'hFFF, 32'hFFFF_FFFF, 1'b1, 1'b1));
    send_visit(make_visit(31, 1'b1, 'h000, 32'hFFFF_FFFE, 1'b0, 1'b1));
    send_visit(make_visit(2, 1'b1, 'h000, 32'h0000_0000, 1'b1, 1'b0));
  endtask

  task automatic test_output_stall();
    visit_t v;
    src_idle_on   = 1'b0;
    stall_request = LONG_HOLD;
    for (int k = 0; k < 24; k++) begin
      v = make_visit(k % 4, 1'b1, $urandom_range(0, 8*PAGE_SIZE - 1),
                     $urandom() & 32'h0000_00FF, $urandom_range(0, 3) == 0, k % 3 == 2);
      send_visit(v);
    end
    src_idle_on = 1'b1;
  endtask

  task automatic test_random_visits(input int n_visits);
    visit_t v;
    int     sent;
    int     group_len;
    int     ws_base;
    int     page;
    sent    = 0;
    ws_base = 0;
    while (sent < n_visits) begin
      if ($urandom_range(0, 5) == 0) begin
        src_idle_on = $urandom_range(0, 2) != 0;
        snk_idle_on = $urandom_range(0, 2) != 0;
      end
      if ($urandom_range(0, 19) == 0) ws_base = $urandom_range(0, 31);
      group_len = $urandom_range(1, 8);
      for (int k = 0; k < group_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          v.process    = PROC_W'($urandom());
          v.active     = 1'($urandom_range(0, 1));
          v.pc         = PC_W'($urandom());
          v.mask       = ($urandom_range(0, 15) == 0) ? '0 : $urandom();
          v.frame_free = 1'($urandom_range(0, 1));
        end else begin
          v.process    = PROC_W'(ws_base + $urandom_range(0, 3));
          v.active     = $urandom_range(0, 19) != 0;
          page         = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                     : $urandom_range(0, 7);
          v.pc         = PC_W'(page*PAGE_SIZE + $urandom_range(0, PAGE_SIZE - 1));
          case ($urandom_range(0, 11))
            0:       v.mask = '0;
            1:       v.mask = '1;
            2:       v.mask = $urandom();
            default: v.mask = ($urandom() & 32'h0000_00FF) | (32'h1 << $urandom_range(0, 31));
          endcase
          v.frame_free = $urandom_range(0, 4) == 0;
        end
        v.last = (k == group_len - 1);
        send_visit(v);
      end
      sent += group_len;
    end
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  initial begin : result_sink
    int        stall;
    decision_t want;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (stall_request > 0) begin
        stall         = stall_request;
        stall_request = 0;
      end else begin
        stall = snk_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      results_taken++;
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("unexpected result: outcome %0d victim %0d",
                                  res_if.outcome, res_if.victim_page));
      end else begin
        want = pending_decisions.pop_front();
        if (res_if.outcome !== want.outcome)
          report_mismatch($sformatf("result %0d: outcome %0d, want %s", results_taken,
                                    res_if.outcome, want.outcome.name()));
        if (res_if.victim_page !== want.victim_page)
          report_mismatch($sformatf("result %0d: victim page %0d, want %0d", results_taken,
                                    res_if.victim_page, want.victim_page));
        outcome_seen[int'(want.outcome)]++;
      end
    end
  end

  initial begin
    rst_n                   <= 1'b0;
    item_if.valid           <= 1'b0;
    item_if.process         <= '0;
    item_if.process_active  <= 1'b0;
    item_if.program_counter <= '0;
    item_if.resident_mask   <= '0;
    item_if.frame_free      <= 1'b0;
    item_if.last_in_tick    <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;

    test_directed_cases();
    test_output_stall();
    test_random_visits(610);
    item_if.valid <= 1'b0;

    while (pending_decisions.size() != 0) @(posedge clk_i);
    repeat (4 * (MASK_PAGES + 4)) @(posedge clk_i);

    $display("Ran %0d visits over %0d ticks, %0d results checked, %0d errors.",
             visits_sent, ticks_closed, results_taken, error_count);
    $display("Outcomes: %0d skipped, %0d hits, %0d page-ins, %0d evictions, %0d empty.",
             outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4]);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
